// ===== rtl/core/sitd_pkg.sv =====
package sitd_pkg;

	localparam int VALUE_W = 32;
	localparam int CHAR_W = 8;
	localparam int DIGIT_W = 4;

	// binary bits shifted into the BCD register per pipeline stage
	localparam int STEPS_PER_STAGE = 4;
	localparam int NUM_DABBLE_STAGES = VALUE_W / STEPS_PER_STAGE;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

endpackage

// ===== rtl/core/sitd_dabble_stage.sv =====
module sitd_dabble_stage #(
	parameter int DIGIT_SLOTS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic                                in_neg,
	input  logic [sitd_pkg::VALUE_W-1:0]        in_bin,
	input  logic [sitd_pkg::DIGIT_W*DIGIT_SLOTS-1:0] in_bcd,
	output logic                                out_valid,
	output logic                                out_neg,
	output logic [sitd_pkg::VALUE_W-1:0]        out_bin,
	output logic [sitd_pkg::DIGIT_W*DIGIT_SLOTS-1:0] out_bcd
);

	localparam int BCD_W = sitd_pkg::DIGIT_W * DIGIT_SLOTS;
	localparam int VW = sitd_pkg::VALUE_W;

	logic             valid_s1;
	logic             neg_s1;
	logic [VW-1:0]    bin_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [VW-1:0]    nxt_bin;
	logic [BCD_W-1:0] nxt_bcd;

	// shift-and-add-3, once per step: correct every digit, then shift one binary bit in
	always_comb begin
		nxt_bcd = in_bcd;
		nxt_bin = in_bin;
		for (int s = 0; s < sitd_pkg::STEPS_PER_STAGE; s++) begin
			for (int d = 0; d < DIGIT_SLOTS; d++) begin
				if (nxt_bcd[sitd_pkg::DIGIT_W*d +: sitd_pkg::DIGIT_W] >= 4'd5) begin
					nxt_bcd[sitd_pkg::DIGIT_W*d +: sitd_pkg::DIGIT_W] =
						nxt_bcd[sitd_pkg::DIGIT_W*d +: sitd_pkg::DIGIT_W] + 4'd3;
				end
			end
			nxt_bcd = {nxt_bcd[BCD_W-2:0], nxt_bin[VW-1]};
			nxt_bin = {nxt_bin[VW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= in_neg;
			bin_s1 <= nxt_bin;
			bcd_s1 <= nxt_bcd;
		end
	end

	assign out_valid = valid_s1;
	assign out_neg   = neg_s1;
	assign out_bin   = bin_s1;
	assign out_bcd   = bcd_s1;

endmodule

// ===== rtl/core/sitd_align.sv =====
module sitd_align #(
	parameter int DIGIT_SLOTS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     in_valid,
	input  logic                                     in_neg,
	input  logic [sitd_pkg::DIGIT_W*DIGIT_SLOTS-1:0] in_bcd,
	output logic                                     out_valid,
	output logic                                     out_neg,
	output logic [sitd_pkg::DIGIT_W*DIGIT_SLOTS-1:0] out_bcd,
	output logic [$clog2(DIGIT_SLOTS+1)-1:0]         out_ndig
);

	localparam int BCD_W = sitd_pkg::DIGIT_W * DIGIT_SLOTS;
	localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

	logic             valid_s1;
	logic             neg_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [CNT_W-1:0] lz_s1;
	logic             valid_s2;
	logic             neg_s2;
	logic [BCD_W-1:0] bcd_s2;
	logic [CNT_W-1:0] ndig_s2;
	logic [CNT_W-1:0] lz;
	logic             found;

	// leading zero digits; the lowest digit always counts, so zero gives "0"
	always_comb begin
		lz = '0;
		found = 1'b0;
		for (int d = DIGIT_SLOTS - 1; d >= 1; d--) begin
			if (found || (in_bcd[sitd_pkg::DIGIT_W*d +: sitd_pkg::DIGIT_W] != 4'd0)) begin
				found = 1'b1;
			end else begin
				lz = lz + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= in_neg;
			bcd_s1  <= in_bcd;
			lz_s1   <= lz;
			neg_s2  <= neg_s1;
			bcd_s2  <= bcd_s1 << {lz_s1, 2'b00};
			ndig_s2 <= CNT_W'(DIGIT_SLOTS) - lz_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_neg   = neg_s2;
	assign out_bcd   = bcd_s2;
	assign out_ndig  = ndig_s2;

endmodule

// ===== rtl/core/sitd_serializer.sv =====
module sitd_serializer #(
	parameter int DIGIT_SLOTS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic                                     in_neg,
	input  logic [sitd_pkg::DIGIT_W*DIGIT_SLOTS-1:0] in_bcd,
	input  logic [$clog2(DIGIT_SLOTS+1)-1:0]         in_ndig,
	output logic                                     load,
	output logic                                     char_valid,
	input  logic                                     char_stall,
	output logic [sitd_pkg::CHAR_W-1:0]              char_code,
	output logic                                     last_char
);

	localparam int BCD_W = sitd_pkg::DIGIT_W * DIGIT_SLOTS;
	localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

	logic                        busy_q;
	logic                        sign_q;
	logic [BCD_W-1:0]            dig_q;
	logic [CNT_W-1:0]            left_q;
	logic                        valid_q;
	logic [sitd_pkg::CHAR_W-1:0] char_q;
	logic                        last_q;
	logic                        slot_free;
	logic                        emit;
	logic                        final_digit;
	logic                        fin;
	logic [sitd_pkg::DIGIT_W-1:0] top_digit;

	assign slot_free   = !valid_q || !char_stall;
	assign emit        = busy_q && slot_free;
	assign final_digit = !sign_q && (left_q == CNT_W'(1));
	assign fin         = emit && final_digit;
	// a request loads when idle, or as the current one sends its last character
	assign load        = in_valid && (!busy_q || fin);
	assign top_digit   = dig_q[BCD_W-1 -: sitd_pkg::DIGIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				valid_q <= emit;
			end
			if (load) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= sign_q ? sitd_pkg::ASCII_MINUS
			                 : sitd_pkg::ASCII_ZERO + {4'b0000, top_digit};
			last_q <= final_digit;
		end
		if (load) begin
			sign_q <= in_neg;
			dig_q  <= in_bcd;
			left_q <= in_ndig;
		end else if (emit) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				dig_q  <= dig_q << sitd_pkg::DIGIT_W;
				left_q <= left_q - CNT_W'(1);
			end
		end
	end

	assign char_valid = valid_q;
	assign char_code  = char_q;
	assign last_char  = last_q;

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Converts a signed 32-bit integer to its decimal text, one ASCII character per
// output request: '-' for a negative value, then the digits with leading zeros
// dropped ("0" for zero, "-2147483648" for the most negative value); last_char
// marks the final character. A request accepted on the item side passes
// through one negate stage, eight double-dabble stages of four bits each and
// two digit-alignment stages to the character serializer, which loads it and
// then registers its characters. The pipeline takes a new request every cycle
// while the serializer has room; sustained throughput is set by the serializer,
// which sends one character per cycle unless char_stall holds it, so a number
// takes 1 to 11 character slots (sign plus digit count) and back-to-back
// numbers follow with no gap. Nothing is kept between numbers.
module signed_int_to_decimal_ascii #(
	parameter int DIGIT_SLOTS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic signed [sitd_pkg::VALUE_W-1:0] value,
	output logic                               char_valid,
	input  logic                               char_stall,
	output logic [sitd_pkg::CHAR_W-1:0]        char_code,
	output logic                               last_char
);

	localparam int BCD_W = sitd_pkg::DIGIT_W * DIGIT_SLOTS;
	localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
	localparam int NSTG = sitd_pkg::NUM_DABBLE_STAGES;
	localparam int VW = sitd_pkg::VALUE_W;

	logic             en;
	logic             load;
	logic [VW-1:0]    raw;
	logic             valid_s1;
	logic             neg_s1;
	logic [VW-1:0]    mag_s1;

	logic             st_valid [0:NSTG];
	logic             st_neg   [0:NSTG];
	logic [VW-1:0]    st_bin   [0:NSTG];
	logic [BCD_W-1:0] st_bcd   [0:NSTG];

	logic             al_valid;
	logic             al_neg;
	logic [BCD_W-1:0] al_bcd;
	logic [CNT_W-1:0] al_ndig;

	// the whole pipeline holds only while a finished request waits on the serializer
	assign en         = !(al_valid && !load);
	assign item_stall = !en;
	assign raw        = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
		end
	end

	// magnitude on 32 unsigned bits covers the most negative value
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= raw[VW-1];
			mag_s1 <= raw[VW-1] ? (~raw + VW'(1)) : raw;
		end
	end

	assign st_valid[0] = valid_s1;
	assign st_neg[0]   = neg_s1;
	assign st_bin[0]   = mag_s1;
	assign st_bcd[0]   = '0;

	for (genvar g = 0; g < NSTG; g++) begin : g_dabble
		sitd_dabble_stage #(
			.DIGIT_SLOTS(DIGIT_SLOTS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (st_valid[g]),
			.in_neg   (st_neg[g]),
			.in_bin   (st_bin[g]),
			.in_bcd   (st_bcd[g]),
			.out_valid(st_valid[g+1]),
			.out_neg  (st_neg[g+1]),
			.out_bin  (st_bin[g+1]),
			.out_bcd  (st_bcd[g+1])
		);
	end

	sitd_align #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (st_valid[NSTG]),
		.in_neg   (st_neg[NSTG]),
		.in_bcd   (st_bcd[NSTG]),
		.out_valid(al_valid),
		.out_neg  (al_neg),
		.out_bcd  (al_bcd),
		.out_ndig (al_ndig)
	);

	sitd_serializer #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (al_valid),
		.in_neg    (al_neg),
		.in_bcd    (al_bcd),
		.in_ndig   (al_ndig),
		.load      (load),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule

// ===== rtl/core/sitd_checker.sv =====
module sitd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               char_valid,
	input logic                               char_stall,
	input logic [sitd_pkg::CHAR_W-1:0]        char_code,
	input logic                               last_char
);

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (char_code == sitd_pkg::ASCII_MINUS) ||
		               ((char_code >= sitd_pkg::ASCII_ZERO) && (char_code <= sitd_pkg::ASCII_NINE)))
		else $error("character outside sign and digits");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (char_code == sitd_pkg::ASCII_MINUS) |-> !last_char)
		else $error("minus sign ends a number");

	// a number's text never starts with a zero unless it is exactly "0"
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && (last_char || (char_code == sitd_pkg::ASCII_MINUS)) ##1
		char_valid && (char_code == sitd_pkg::ASCII_ZERO) |-> last_char)
		else $error("leading zero in number text");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_code) && $stable(last_char))
		else $error("stalled character changed");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (.*);
